// File: hw/rtl/flu_pkg.sv
// ----------------------------------------------------------------------------
// flu_pkg: shared types and constants of the 8080/Z80 flag unit
// Command codes, flag bit masks and the records passed between pipeline stages.
// ----------------------------------------------------------------------------
package flu_pkg;

  localparam logic [3:0] CMD_SZP_MASK = 4'd0;
  localparam logic [3:0] CMD_LOGIC    = 4'd1;
  localparam logic [3:0] CMD_INC      = 4'd2;
  localparam logic [3:0] CMD_DEC      = 4'd3;
  localparam logic [3:0] CMD_ADD      = 4'd4;
  localparam logic [3:0] CMD_SUB      = 4'd5;
  localparam logic [3:0] CMD_ADC      = 4'd6;
  localparam logic [3:0] CMD_SBB      = 4'd7;
  localparam logic [3:0] CMD_Z_ROT    = 4'd8;
  localparam logic [3:0] CMD_Z_INC    = 4'd9;
  localparam logic [3:0] CMD_Z_DEC    = 4'd10;
  localparam logic [3:0] CMD_Z_ADD    = 4'd11;
  localparam logic [3:0] CMD_Z_ADD16  = 4'd12;
  localparam logic [3:0] CMD_Z_ADD16S = 4'd13;
  localparam logic [3:0] CMD_Z_SUB    = 4'd14;
  localparam logic [3:0] CMD_Z_SUB16  = 4'd15;

  localparam logic [7:0] FLG_S = 8'h80;
  localparam logic [7:0] FLG_Z = 8'h40;
  localparam logic [7:0] FLG_A = 8'h10;
  localparam logic [7:0] FLG_P = 8'h04;
  localparam logic [7:0] FLG_N = 8'h02;
  localparam logic [7:0] FLG_C = 8'h01;
  localparam logic [7:0] FLG_ARITH = FLG_S | FLG_Z | FLG_A | FLG_P | FLG_C;

  localparam logic [7:0] BYTE_INC_OVF = 8'h7f;
  localparam logic [7:0] BYTE_DEC_OVF = 8'h80;

  // Stage 1 record: byte result and raw condition bits
  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] old_flags;
    logic [8:0] res;
    logic       half;
    logic       ovf;
    logic       wsign;
    logic       wzero;
    logic       c16;
    logic       cin;
    logic [7:0] set_mask;
    logic [7:0] clear_mask;
  } s1_t;

  // Stage 2 record: flags to clear and flags to set
  typedef struct packed {
    logic [7:0] old_flags;
    logic [7:0] clr;
    logic [7:0] set;
  } s2_t;

endpackage

// File: hw/rtl/flu_front.sv
// ----------------------------------------------------------------------------
// flu_front: first pipeline stage
// Forms the 9-bit byte result, half carry, overflow and word conditions.
// ----------------------------------------------------------------------------
module flu_front import flu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [3:0]  command,
  input  logic [7:0]  old_flags,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic        carry_in,
  input  logic [16:0] result_in,
  input  logic [7:0]  set_mask,
  input  logic [7:0]  clear_mask,
  output s1_t         s1
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [8:0]  a9;
  logic [8:0]  b9;
  logic [8:0]  c9;
  logic [15:0] wx;
  s1_t         s1_next;

  assign a8 = operand_a[7:0];
  assign b8 = operand_b[7:0];
  assign a9 = {1'b0, a8};
  assign b9 = {1'b0, b8};
  assign c9 = {8'd0, carry_in};
  assign wx = operand_a ^ operand_b ^ result_in[15:0];

  always_comb begin
    s1_next            = '0;
    s1_next.cmd        = command;
    s1_next.old_flags  = old_flags;
    s1_next.cin        = carry_in;
    s1_next.set_mask   = set_mask;
    s1_next.clear_mask = clear_mask;
    s1_next.wsign      = result_in[15];
    s1_next.wzero      = (result_in[15:0] == 16'd0);
    s1_next.c16        = result_in[16];
    s1_next.res        = a9;
    case (command)
      CMD_INC, CMD_Z_INC: begin
        s1_next.res  = a9 + 9'd1;
        s1_next.half = a8[4] ^ s1_next.res[4];
        s1_next.ovf  = (a8 == BYTE_INC_OVF);
      end
      CMD_DEC, CMD_Z_DEC: begin
        s1_next.res  = a9 - 9'd1;
        s1_next.half = a8[4] ^ s1_next.res[4];
        s1_next.ovf  = (a8 == BYTE_DEC_OVF);
      end
      CMD_ADD, CMD_SUB, CMD_ADC, CMD_SBB: begin
        case (command)
          CMD_ADD: s1_next.res = a9 + b9;
          CMD_SUB: s1_next.res = a9 - b9;
          CMD_ADC: s1_next.res = a9 + b9 + c9;
          default: s1_next.res = a9 - b9 - c9;
        endcase
        s1_next.half = a8[4] ^ b8[4] ^ s1_next.res[4];
      end
      CMD_Z_ADD, CMD_Z_SUB: begin
        s1_next.res  = result_in[8:0];
        s1_next.half = a8[4] ^ b8[4] ^ result_in[4];
        if (command == CMD_Z_ADD) begin
          s1_next.ovf = (result_in[7] ^ a8[7]) & (result_in[7] ^ b8[7]);
        end else begin
          s1_next.ovf = (a8[7] ^ result_in[7]) & (a8[7] ^ b8[7]);
        end
      end
      CMD_Z_ADD16, CMD_Z_ADD16S, CMD_Z_SUB16: begin
        s1_next.half = wx[12];
        if (command == CMD_Z_SUB16) begin
          s1_next.ovf = (operand_a[15] ^ result_in[15]) & (operand_a[15] ^ operand_b[15]);
        end else begin
          s1_next.ovf = (operand_a[15] ^ result_in[15]) & ~(operand_a[15] ^ operand_b[15]);
        end
      end
      default: begin
        s1_next.res = a9;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

endmodule

// File: hw/rtl/flu_flags.sv
// ----------------------------------------------------------------------------
// flu_flags: second pipeline stage
// Turns the stage 1 conditions into per-command clear and set masks.
// ----------------------------------------------------------------------------
module flu_flags import flu_pkg::*; (
  input  logic clk,
  input  logic en,
  input  s1_t  s1,
  output s2_t  s2
);

  logic       bz;
  logic       bp;
  logic [7:0] sz;
  logic [7:0] szp;
  logic [7:0] fa;
  logic [7:0] fp;
  s2_t        s2_next;

  assign bz  = (s1.res[7:0] == 8'd0);
  assign bp  = ~^s1.res[7:0];
  assign sz  = (s1.res[7] ? FLG_S : 8'd0) | (bz ? FLG_Z : 8'd0);
  assign szp = sz | (bp ? FLG_P : 8'd0);
  assign fa  = s1.half ? FLG_A : 8'd0;
  assign fp  = s1.ovf ? FLG_P : 8'd0;

  always_comb begin
    s2_next.old_flags = s1.old_flags;
    case (s1.cmd)
      CMD_SZP_MASK: begin
        s2_next.clr = FLG_S | FLG_Z | FLG_P | s1.clear_mask;
        s2_next.set = szp | s1.set_mask;
      end
      CMD_LOGIC: begin
        s2_next.clr = FLG_S | FLG_Z | FLG_P | FLG_C;
        s2_next.set = szp;
      end
      CMD_INC, CMD_DEC: begin
        s2_next.clr = FLG_S | FLG_Z | FLG_A | FLG_P;
        s2_next.set = szp | fa;
      end
      CMD_ADD, CMD_SUB, CMD_ADC, CMD_SBB: begin
        s2_next.clr = FLG_ARITH;
        s2_next.set = szp | fa | (s1.res[8] ? FLG_C : 8'd0);
      end
      CMD_Z_ROT: begin
        s2_next.clr = FLG_ARITH | FLG_N;
        s2_next.set = szp | (s1.cin ? FLG_C : 8'd0);
      end
      CMD_Z_INC, CMD_Z_DEC: begin
        s2_next.clr = FLG_S | FLG_Z | FLG_A | FLG_P | FLG_N;
        s2_next.set = sz | fa | fp | ((s1.cmd == CMD_Z_DEC) ? FLG_N : 8'd0);
      end
      CMD_Z_ADD, CMD_Z_SUB: begin
        s2_next.clr = FLG_ARITH | FLG_N;
        s2_next.set = sz | fa | fp | (s1.res[8] ? FLG_C : 8'd0)
                    | ((s1.cmd == CMD_Z_SUB) ? FLG_N : 8'd0);
      end
      CMD_Z_ADD16: begin
        s2_next.clr = FLG_A | FLG_N | FLG_C;
        s2_next.set = fa | (s1.c16 ? FLG_C : 8'd0);
      end
      default: begin
        // word add with S/Z and word subtract
        s2_next.clr = FLG_ARITH | FLG_N;
        s2_next.set = (s1.wsign ? FLG_S : 8'd0) | (s1.wzero ? FLG_Z : 8'd0)
                    | (s1.c16 ? FLG_C : 8'd0) | fa | fp
                    | ((s1.cmd == CMD_Z_SUB16) ? FLG_N : 8'd0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

endmodule

// File: hw/rtl/i8080_z80_flag_unit_top.sv
// ----------------------------------------------------------------------------
// i8080_z80_flag_unit_top: 8080/Z80 status flag generator
// Three-stage pipeline: condition bits, flag masks, merged output register.
// Path: an accepted word moves through stage 1, stage 2 and the output register to out_valid.
// Throughput: one word per cycle unless out_ready stalls; each stage advances when the next has room.
// Reset clears the stage valid bits only; the stage data registers are not reset.
// ----------------------------------------------------------------------------
module i8080_z80_flag_unit_top import flu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  command,
  input  logic [7:0]  old_flags,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic        carry_in,
  input  logic [16:0] result_in,
  input  logic [7:0]  set_mask,
  input  logic [7:0]  clear_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  new_flags
);

  logic v1;
  logic v2;
  logic v3;
  logic en1;
  logic en2;
  logic en3;
  s1_t  s1;
  s2_t  s2;

  // advance a stage when it is empty or its word moves on
  assign en3      = ~v3 | out_ready;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign in_ready = en1;
  assign out_valid = v3;

  flu_front u_front (
    .clk        (clk),
    .en         (en1),
    .command    (command),
    .old_flags  (old_flags),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .carry_in   (carry_in),
    .result_in  (result_in),
    .set_mask   (set_mask),
    .clear_mask (clear_mask),
    .s1         (s1)
  );

  flu_flags u_flags (
    .clk (clk),
    .en  (en2),
    .s1  (s1),
    .s2  (s2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      new_flags <= (s2.old_flags & ~s2.clr) | s2.set;
    end
  end

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted word did not reach stage 1");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !en2 |=> v1 && $stable(s1))
    else $error("stage 1 word changed while stalled");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !en3 |=> v2 && $stable(s2))
    else $error("stage 2 word changed while stalled");

  a_s2_moves: assert property (@(posedge clk) disable iff (rst)
    v2 && en3 |=> v3)
    else $error("stage 2 word lost on advance");

endmodule
